>>> design/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
`timescale 1ns / 1ps

package sobel_pkg;

	localparam int PADDR_W = 3;

	localparam logic REG_IMAGE_WIDTH    = 1'b0;
	localparam logic REG_GRAD_THRESHOLD = 1'b1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	localparam logic [10:0] IMAGE_WIDTH_RST    = 11'd640;
	localparam logic [10:0] GRAD_THRESHOLD_RST = 11'd110;
	localparam logic [21:0] THR_SQ_RST         = 22'd12100;
	localparam logic [20:0] GRAD_SQ_MAX        = 21'd2080800;

	typedef struct packed {
		logic       req_type;
		logic [7:0] pixel;
	} pix_in_t;

	typedef struct packed {
		logic [20:0] grad_sq;
		logic        edge_res;
		logic        frame_last;
	} edge_out_t;

	typedef struct packed {
		logic [10:0] image_width;
		logic [21:0] thr_sq;
	} cfg_t;

	typedef struct packed {
		logic signed [10:0] gh;
		logic signed [10:0] gv;
	} grad_t;

	typedef struct packed {
		grad_t g0;
		grad_t g1;
		logic  en0;
		logic  en1;
		logic  last;
	} grad_pair_t;

endpackage

>>> design/sobel_edge_threshold_top.sv
// Top level of the streaming 3x3 Sobel edge detector with threshold.
//
// Input channel (in_valid / in_stall / in_data): grey pixels in raster order,
// or flush transactions (req_type set), one per column, after the last row.
// Output channel (out_valid / out_stall / out_data): one result per pixel,
// lagging one row and one pixel; the last transaction of a row also yields
// the row's final column, the final flush one carries frame_last.
// Throughput: one input transaction per clock while in_stall is low; a row-end
// transaction with two results occupies the output register until both have
// been taken, as there is a single result port. Pipeline: input stage with
// line-buffer read, window and gradients, squares, threshold compare into the
// output buffer.
// Reset: row position, window and pipeline valids clear; image_width returns
// to 640, grad_threshold to 110. Line buffers are not cleared.
// A stalled output holds its transaction; the pipeline fills and in_stall
// rises once every stage is occupied.
`timescale 1ns / 1ps

module sobel_edge_threshold_top
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pix_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output edge_out_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t       cfg;
	logic       grad_valid, grad_stall;
	grad_pair_t grad_data;

	sobel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sobel_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.image_width (cfg.image_width),
		.grad_valid  (grad_valid),
		.grad_stall  (grad_stall),
		.grad_data   (grad_data)
	);

	sobel_mag u_mag (
		.clk        (clk),
		.arst_n     (arst_n),
		.grad_valid (grad_valid),
		.grad_stall (grad_stall),
		.grad_data  (grad_data),
		.thr_sq     (cfg.thr_sq),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

>>> design/sobel_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/sobel_cfg.sv
// APB configuration registers and threshold square.
`timescale 1ns / 1ps

module sobel_cfg
	import sobel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [10:0] image_width_q;
	logic [10:0] grad_threshold_q;
	logic [21:0] thr_sq_q;
	logic        reg_idx;
	logic        wr;

	assign reg_idx = paddr[PADDR_W-1];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= IMAGE_WIDTH_RST;
			grad_threshold_q <= GRAD_THRESHOLD_RST;
			thr_sq_q         <= THR_SQ_RST;
		end else begin
			if (wr) begin
				unique case (reg_idx)
					REG_IMAGE_WIDTH:    image_width_q    <= pwdata[10:0];
					REG_GRAD_THRESHOLD: grad_threshold_q <= pwdata[10:0];
				endcase
			end
			thr_sq_q <= 22'(grad_threshold_q) * 22'(grad_threshold_q);
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:    prdata = {21'd0, image_width_q};
			REG_GRAD_THRESHOLD: prdata = {21'd0, grad_threshold_q};
		endcase
	end

	assign cfg.image_width = image_width_q;
	assign cfg.thr_sq      = thr_sq_q;

endmodule

>>> design/sobel_window.sv
// Row tracking, line buffers, 3x3 window and Sobel gradients.
`timescale 1ns / 1ps

module sobel_window
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pix_in_t     in_data,
	input  logic [10:0] image_width,
	output logic        grad_valid,
	input  logic        grad_stall,
	output grad_pair_t  grad_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_LATER  = 2'd2;

	typedef logic [2:0][7:0] column_t;

	function automatic grad_t sobel_grad(column_t l, column_t c, column_t r);
		logic [9:0] rs, ls, bs, ts;
		grad_t      g;
		rs   = {2'b0, r[0]} + {1'b0, r[1], 1'b0} + {2'b0, r[2]};
		ls   = {2'b0, l[0]} + {1'b0, l[1], 1'b0} + {2'b0, l[2]};
		bs   = {2'b0, l[2]} + {1'b0, c[2], 1'b0} + {2'b0, r[2]};
		ts   = {2'b0, l[0]} + {1'b0, c[0], 1'b0} + {2'b0, r[0]};
		g.gh = $signed({1'b0, rs}) - $signed({1'b0, ls});
		g.gv = $signed({1'b0, bs}) - $signed({1'b0, ts});
		return g;
	endfunction

	logic [CW-1:0] col_q;
	logic [1:0]    phase_q;
	logic [WW-1:0] iw_ext, wsat;
	logic          row_end_in, flush_in, ignore, acc, load_s1, fwd_hit;

	logic          v_s1, flush_s1, phnz_s1, ph2_s1, rend_s1, fwd_s1;
	logic [CW-1:0] col_s1;
	logic [7:0]    pix_s1, fmid_s1, ftop_s1;
	logic          s1_adv, s1_free, s2_free, load_s2;
	logic [7:0]    rd1, rd2, mid_w, top_raw, top_w, bot_w;
	logic          first, res0, res1;

	logic          v_s2;
	column_t       win_q [3];
	column_t       win_n [3];
	column_t       new_col;

	assign iw_ext = WW'(image_width);
	assign wsat   = (iw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
	                (iw_ext == '0) ? WW'(1) : iw_ext;
	assign row_end_in = (WW'(col_q) + WW'(1)) >= wsat;
	assign flush_in   = in_data.req_type == REQ_FLUSH;
	assign ignore     = flush_in && (phase_q == PH_FIRST);

	assign s2_free  = !v_s2 || !grad_stall;
	assign s1_adv   = v_s1 && s2_free;
	assign s1_free  = !v_s1 || s2_free;
	assign in_stall = !s1_free;
	assign acc      = in_valid && !in_stall;
	assign load_s1  = acc && !ignore;
	assign fwd_hit  = s1_adv && (col_s1 == col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= PH_FIRST;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (load_s1) begin
				if (row_end_in) begin
					col_q <= '0;
					if (flush_in) begin
						phase_q <= PH_FIRST;
					end else if (phase_q == PH_FIRST) begin
						phase_q <= PH_SECOND;
					end else begin
						phase_q <= PH_LATER;
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (s1_free) begin
				v_s1 <= load_s1;
			end
			if (s2_free) begin
				v_s2 <= load_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			col_s1   <= col_q;
			flush_s1 <= flush_in;
			pix_s1   <= in_data.pixel;
			phnz_s1  <= phase_q != PH_FIRST;
			ph2_s1   <= phase_q == PH_LATER;
			rend_s1  <= row_end_in;
			fwd_s1   <= fwd_hit;
			fmid_s1  <= bot_w;
			ftop_s1  <= mid_w;
		end
	end

	sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row1 (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (bot_w),
		.re    (load_s1),
		.raddr (col_q),
		.rdata (rd1)
	);

	sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row2 (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (mid_w),
		.re    (load_s1),
		.raddr (col_q),
		.rdata (rd2)
	);

	// same-column back-to-back (one-pixel rows) bypasses the RAM
	assign mid_w   = fwd_s1 ? fmid_s1 : rd1;
	assign top_raw = fwd_s1 ? ftop_s1 : rd2;
	assign top_w   = ph2_s1 ? top_raw : mid_w;
	assign bot_w   = flush_s1 ? mid_w : pix_s1;
	assign first   = col_s1 == '0;
	assign res0    = phnz_s1 && !first;
	assign res1    = phnz_s1 && rend_s1;
	assign load_s2 = s1_adv && (res0 || res1);

	always_comb begin
		new_col[0] = top_w;
		new_col[1] = mid_w;
		new_col[2] = bot_w;
		if (first) begin
			win_n[0] = new_col;
			win_n[1] = new_col;
			win_n[2] = new_col;
		end else begin
			win_n[0] = win_q[1];
			win_n[1] = win_q[2];
			win_n[2] = new_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (s1_adv) begin
			win_q[0] <= win_n[0];
			win_q[1] <= win_n[1];
			win_q[2] <= win_n[2];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			grad_data.g0   <= sobel_grad(win_n[0], win_n[1], win_n[2]);
			grad_data.g1   <= sobel_grad(win_n[1], win_n[2], win_n[2]);
			grad_data.en0  <= res0;
			grad_data.en1  <= res1;
			grad_data.last <= flush_s1;
		end
	end

	assign grad_valid = v_s2;

endmodule

>>> design/sobel_mag.sv
// Squared gradient magnitude, threshold compare and result buffer.
`timescale 1ns / 1ps

module sobel_mag
	import sobel_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        grad_valid,
	output logic        grad_stall,
	input  grad_pair_t  grad_data,
	input  logic [21:0] thr_sq,
	output logic        out_valid,
	input  logic        out_stall,
	output edge_out_t   out_data
);

	logic               v_s3, en0_s3, en1_s3, last_s3;
	logic [20:0]        g2a_s3, g2b_s3;
	logic signed [21:0] pha, pva, phb, pvb;
	logic               ov0_q, ov1_q;
	edge_out_t          od0_q, od1_q;
	logic               out_acc, out_free, s3_free, out_load;

	assign pha = grad_data.g0.gh * grad_data.g0.gh;
	assign pva = grad_data.g0.gv * grad_data.g0.gv;
	assign phb = grad_data.g1.gh * grad_data.g1.gh;
	assign pvb = grad_data.g1.gv * grad_data.g1.gv;

	assign out_valid  = ov0_q || ov1_q;
	assign out_data   = ov0_q ? od0_q : od1_q;
	assign out_acc    = out_valid && !out_stall;
	assign out_free   = !out_valid || (out_acc && !(ov0_q && ov1_q));
	assign s3_free    = !v_s3 || out_free;
	assign grad_stall = !s3_free;
	assign out_load   = v_s3 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			ov0_q <= 1'b0;
			ov1_q <= 1'b0;
		end else begin
			if (s3_free) begin
				v_s3 <= grad_valid;
			end
			if (out_load) begin
				ov0_q <= en0_s3;
				ov1_q <= en1_s3;
			end else if (out_acc) begin
				if (ov0_q) begin
					ov0_q <= 1'b0;
				end else begin
					ov1_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && grad_valid) begin
			g2a_s3  <= 21'(pha[19:0]) + 21'(pva[19:0]);
			g2b_s3  <= 21'(phb[19:0]) + 21'(pvb[19:0]);
			en0_s3  <= grad_data.en0;
			en1_s3  <= grad_data.en1;
			last_s3 <= grad_data.last;
		end
		if (out_load) begin
			od0_q.grad_sq    <= g2a_s3;
			od0_q.edge_res   <= {1'b0, g2a_s3} > thr_sq;
			od0_q.frame_last <= 1'b0;
			od1_q.grad_sq    <= g2b_s3;
			od1_q.edge_res   <= {1'b0, g2b_s3} > thr_sq;
			od1_q.frame_last <= last_s3;
		end
	end

endmodule

>>> design/sobel_chk.sv
// Port-level checks for the Sobel edge threshold block, bound to the top.
`timescale 1ns / 1ps

module sobel_chk
	import sobel_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input edge_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed");

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	a_reset_lag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("output valid straight after reset");

	a_grad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.grad_sq <= GRAD_SQ_MAX)
		else $error("gradient square out of range");

endmodule

bind sobel_edge_threshold_top sobel_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/sobel_edge_threshold_checker.sv
// Checker for the Sobel edge threshold block: mirrors the registers, predicts results, compares.
`timescale 1ns / 1ps

module sobel_edge_threshold_checker
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  pix_in_t            in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  edge_out_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output int                 fail_count,
	output int                 pending_results
);

	localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH    = {REG_IMAGE_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_GRAD_THRESHOLD = {REG_GRAD_THRESHOLD, 2'b00};

	typedef enum logic [1:0] {ROW_FIRST, ROW_SECOND, ROW_LATER} row_phase_t;

	// [0] top, [1] middle, [2] bottom row of one window column
	typedef logic [2:0][7:0] px_col_t;

	logic [10:0] width_reg = IMAGE_WIDTH_RST;
	logic [10:0] thr_reg   = GRAD_THRESHOLD_RST;
	logic [7:0]  line_above [MAX_WIDTH];
	logic [7:0]  line_two_above [MAX_WIDTH];
	px_col_t     sobel_win [3];
	int          col_pos = 0;
	row_phase_t  row_phase = ROW_FIRST;

	edge_out_t   expected_edges [$];
	edge_out_t   oldest_edge;
	int          mismatch_count = 0;
	int          queued = 0;

	assign fail_count      = mismatch_count;
	assign pending_results = queued;

	initial begin
		for (int j = 0; j < 3; j++)
			sobel_win[j] = '0;
	end

	function automatic edge_out_t sobel_grad_result(input px_col_t lc, input px_col_t mc,
			input px_col_t rc, input logic is_last);
		int        gh;
		int        gv;
		int        g2;
		int        t2;
		edge_out_t res;
		gh = int'(rc[0]) + 2 * int'(rc[1]) + int'(rc[2])
			- int'(lc[0]) - 2 * int'(lc[1]) - int'(lc[2]);
		gv = int'(lc[2]) + 2 * int'(mc[2]) + int'(rc[2])
			- int'(lc[0]) - 2 * int'(mc[0]) - int'(rc[0]);
		g2 = gh * gh + gv * gv;
		t2 = int'(thr_reg) * int'(thr_reg);
		res.grad_sq    = g2[20:0];
		res.edge_res   = (g2 > t2);
		res.frame_last = is_last;
		return res;
	endfunction

	task automatic predict_sobel_pixel(input pix_in_t item);
		int         w;
		int         c;
		int         idx;
		logic       is_flush;
		logic       row_end;
		logic [7:0] top_px;
		logic [7:0] mid_px;
		logic [7:0] bot_px;
		is_flush = (item.req_type == REQ_FLUSH);
		w = int'(width_reg);
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		if (w < 1)
			w = 1;
		if (is_flush && row_phase == ROW_FIRST)
			return;
		c = col_pos;
		idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
		row_end = (c + 1 >= w);

		mid_px = line_above[idx];
		top_px = (row_phase == ROW_LATER) ? line_two_above[idx] : mid_px;
		bot_px = is_flush ? mid_px : item.pixel;
		line_two_above[idx] = mid_px;
		line_above[idx]     = bot_px;

		if (c == 0) begin
			for (int j = 0; j < 3; j++)
				sobel_win[j] = {bot_px, mid_px, top_px};
		end else begin
			sobel_win[0] = sobel_win[1];
			sobel_win[1] = sobel_win[2];
			sobel_win[2] = {bot_px, mid_px, top_px};
		end

		if (row_phase != ROW_FIRST) begin
			if (c != 0)
				expected_edges = {expected_edges, sobel_grad_result(sobel_win[0],
					sobel_win[1], sobel_win[2], 1'b0)};
			// right border: last column repeated
			if (row_end)
				expected_edges = {expected_edges, sobel_grad_result(sobel_win[1],
					sobel_win[2], sobel_win[2], is_flush)};
		end

		if (row_end) begin
			col_pos = 0;
			if (is_flush)
				row_phase = ROW_FIRST;
			else if (row_phase == ROW_FIRST)
				row_phase = ROW_SECOND;
			else
				row_phase = ROW_LATER;
		end else begin
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_edges.size() == 0) begin
					$error("unexpected transaction: grad_sq %0d, edge_res %0b, frame_last %0b",
						out_data.grad_sq, out_data.edge_res, out_data.frame_last);
					mismatch_count++;
				end else begin
					oldest_edge = expected_edges.pop_front();
					if (out_data.grad_sq !== oldest_edge.grad_sq) begin
						$error("grad_sq mismatch: expected %0d, actual %0d",
							oldest_edge.grad_sq, out_data.grad_sq);
						mismatch_count++;
					end
					if (out_data.edge_res !== oldest_edge.edge_res) begin
						$error("edge_res mismatch: expected %0b, actual %0b",
							oldest_edge.edge_res, out_data.edge_res);
						mismatch_count++;
					end
					if (out_data.frame_last !== oldest_edge.frame_last) begin
						$error("frame_last mismatch: expected %0b, actual %0b",
							oldest_edge.frame_last, out_data.frame_last);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_sobel_pixel(in_data);
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_IMAGE_WIDTH)
					width_reg = pwdata[10:0];
				else if (paddr == ADDR_GRAD_THRESHOLD)
					thr_reg = pwdata[10:0];
			end
			queued = expected_edges.size();
		end
	end

endmodule

>>> tb/sobel_edge_threshold_top_tb.sv
// Testbench top for the Sobel edge threshold block: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module sobel_edge_threshold_top_tb;
	import sobel_pkg::*;

	localparam int MAX_WIDTH    = 1024;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 400;
	localparam int WIDE_ITEMS   = 64;

	localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH    = {REG_IMAGE_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_GRAD_THRESHOLD = {REG_GRAD_THRESHOLD, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	pix_in_t            in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	edge_out_t          out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic calm = 1'b0;
	int   fail_count;
	int   pending_results;
	int   quiet_cycles = 0;
	int   sent_items = 0;
	int   tx_pcts [3] = '{13, 64, 0};
	int   rx_pcts [3] = '{64, 13, 0};

	sobel_edge_threshold_top #(
		.MAX_WIDTH(MAX_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	sobel_edge_threshold_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] px);
		while (!calm && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		in_data.req_type <= kind;
		in_data.pixel    <= px;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// leaves the bus in its access phase; the caller closes the transfer
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [10:0] val);
		logic [31:0] wdata;
		wdata = $urandom();
		wdata[10:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
	endtask

	// registers change only once the block has drained
	task automatic setup_frame(input logic [10:0] width_val, input logic [10:0] thr_val);
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		write_reg(ADDR_IMAGE_WIDTH, width_val);
		write_reg(ADDR_GRAD_THRESHOLD, thr_val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic run_frame(input int w_eff, input int rows, input int flush_pct);
		logic       kind;
		logic [7:0] px;
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < w_eff; c++) begin
				kind = (r > 0 && $urandom_range(99) < flush_pct) ? REQ_FLUSH : REQ_PIXEL;
				if ($urandom_range(3) == 0)
					px = $urandom_range(1) ? 8'hFF : 8'h00;
				else
					px = 8'($urandom_range(255));
				send_item(kind, px);
				sent_items++;
			end
		end
		for (int c = 0; c < w_eff; c++) begin
			send_item(REQ_FLUSH, 8'($urandom_range(255)));
			sent_items++;
		end
	endtask

	task automatic random_frame();
		int w_val;
		int thr_val;
		case ($urandom_range(9))
			0: w_val = $urandom_range(2);
			1: w_val = $urandom_range(40, 17);
			default: w_val = $urandom_range(16, 3);
		endcase
		case ($urandom_range(5))
			0: thr_val = 0;
			1: thr_val = 1443;
			2: thr_val = 2047;
			3: thr_val = $urandom_range(2047);
			default: thr_val = $urandom_range(400, 40);
		endcase
		setup_frame(w_val[10:0], thr_val[10:0]);
		calm <= ($urandom_range(3) == 0);
		// flushes before a frame starts are dropped by the block
		repeat ($urandom_range(2)) send_item(REQ_FLUSH, 8'($urandom_range(255)));
		run_frame((w_val == 0) ? 1 : w_val, $urandom_range(6, 1),
			($urandom_range(3) == 0) ? 10 : 0);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// narrow frame, zero threshold, mid-row flush
		setup_frame(11'd3, 11'd0);
		send_item(REQ_FLUSH, 8'hFF);
		send_item(REQ_PIXEL, 8'h00);
		send_item(REQ_PIXEL, 8'hFF);
		send_item(REQ_PIXEL, 8'h00);
		send_item(REQ_PIXEL, 8'hFF);
		send_item(REQ_PIXEL, 8'h00);
		send_item(REQ_PIXEL, 8'hFF);
		send_item(REQ_PIXEL, 8'hA5);
		send_item(REQ_PIXEL, 8'h5A);
		send_item(REQ_PIXEL, 8'hFF);
		send_item(REQ_PIXEL, 8'h00);
		send_item(REQ_FLUSH, 8'h00);
		send_item(REQ_PIXEL, 8'h80);
		send_item(REQ_FLUSH, 8'h00);
		send_item(REQ_FLUSH, 8'hFF);
		send_item(REQ_FLUSH, 8'h00);

		// zero width saturates to one column; gradient equal to threshold
		setup_frame(11'd0, 11'd1020);
		send_item(REQ_PIXEL, 8'hFF);
		send_item(REQ_PIXEL, 8'h00);
		send_item(REQ_FLUSH, 8'h00);

		// flush ending a row cuts the frame short
		setup_frame(11'd2, 11'd2047);
		send_item(REQ_PIXEL, 8'h10);
		send_item(REQ_PIXEL, 8'hF0);
		send_item(REQ_PIXEL, 8'h20);
		send_item(REQ_FLUSH, 8'h00);
		send_item(REQ_FLUSH, 8'h00);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct <= tx_pcts[ph];
			rx_idle_pct <= rx_pcts[ph];
			sent_items = 0;
			while (sent_items < PHASE_ITEMS)
				random_frame();
		end

		// register above the maximum saturates: a long first row never ends early
		setup_frame(11'd1030, 11'($urandom_range(400, 40)));
		calm <= 1'b0;
		repeat (WIDE_ITEMS) send_item(REQ_PIXEL, 8'($urandom_range(255)));

		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
design/sobel_pkg.sv
design/sobel_ram.sv
design/sobel_cfg.sv
design/sobel_window.sv
design/sobel_mag.sv
design/sobel_edge_threshold_top.sv
design/sobel_chk.sv
tb/sobel_edge_threshold_checker.sv
tb/sobel_edge_threshold_top_tb.sv
